FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/ksm_pkg.sv
`default_nettype none

package ksm_pkg;

    localparam int MEAS_W    = 32;
    localparam int VAR_W     = 48;
    localparam int SUM_W     = VAR_W + 1;
    localparam int QUO_W     = 33;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int REM_W     = SUM_W + 1;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 64;
    localparam int HALF_W    = 16;

    localparam logic [VAR_W-1:0] VAR_MAX     = {VAR_W{1'b1}};
    localparam logic [VAR_W-1:0] NOISE_RESET = 48'h0001_0000_0000;

    // Register index codes, taken from the top address bit.
    localparam logic REG_NOISE_VAR = 1'b0;

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_SQ   = 15'h0002,
        ST_PRED = 15'h0004,
        ST_SUM  = 15'h0008,
        ST_GS   = 15'h0010,
        ST_GW   = 15'h0020,
        ST_HS   = 15'h0040,
        ST_HW   = 15'h0080,
        ST_MGL  = 15'h0100,
        ST_MGH  = 15'h0200,
        ST_UPX  = 15'h0400,
        ST_MHL  = 15'h0800,
        ST_MHH  = 15'h1000,
        ST_UPV  = 15'h2000,
        ST_FIN  = 15'h4000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAR_W-1:0] num;
        logic [SUM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/ksm_div.sv
`default_nettype none

module ksm_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire ksm_pkg::t_div_req i_req,
    output ksm_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [ksm_pkg::CNT_W-1:0]     r_cnt;
    logic [ksm_pkg::REM_W-1:0]     r_rem;
    logic [ksm_pkg::QUO_W-1:0]     r_quo;
    logic [ksm_pkg::SUM_W-1:0]     r_den;

    logic [ksm_pkg::REM_W-1:0]     rem2;
    logic                          fits;

    assign rem2 = {r_rem[ksm_pkg::REM_W-2:0], 1'b0};
    assign fits = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ksm_pkg::CNT_W'(ksm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if ({1'b0, i_req.num} == i_req.den) begin
                r_rem <= '0;
                r_quo <= ksm_pkg::QUO_W'(1);
            end else begin
                r_rem <= {2'b00, i_req.num};
                r_quo <= '0;
            end
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rem2 - {1'b0, r_den};
                r_quo <= {r_quo[ksm_pkg::QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_quo <= {r_quo[ksm_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

FILE: hw/rtl/ksm_mul.sv
`default_nettype none

module ksm_mul (
    input  wire                          i_clk,
    input  wire  [ksm_pkg::MUL_W-1:0]    i_a,
    input  wire  [ksm_pkg::MUL_W-1:0]    i_b,
    output logic [ksm_pkg::PROD_W-1:0]   o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scalar_kalman_smoother_unit.sv
`default_nettype none

// Scalar Kalman smoother along a row of Q15.16 samples. Each accepted transaction
// returns one estimate transaction; a sample flagged first_of_row restarts the
// filter and returns the sample itself. The block takes one sample at a time.
// A restart sample goes from the accepting state straight to the output load;
// any other sample passes the squared difference, the predicted variance, the
// sum, two passes of the shared bit-serial divider (a start, 32 quotient steps
// and a done strobe) for the gain and the variance factor, the states MGL, MGH,
// UPX, MHL, MHH and UPV, in which a registered 33x33 multiplier forms four
// partial products and the estimate and variance are updated, and the output
// load, but skips from a zero sum to the output load. A finished estimate waits
// in an output register; the block holds in its last state while that register
// is still unread, and once the estimate is loaded the next sample is taken
// while it waits to be read. The noise variance register (unsigned Q16.32, 48
// bits, reset value 1.0) is selected by a clear top address bit (byte addresses
// 0 to 7) of the 64-bit configuration port; writes to other registers are ignored.

module scalar_kalman_smoother_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  signed [31:0]            i_measurement,
    input  wire                           i_first_of_row,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic signed [31:0]            o_estimate,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [ksm_pkg::ADDR_W-1:0]    paddr,
    input  wire  [ksm_pkg::DATA_W-1:0]    pwdata,
    output logic [ksm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    ksm_pkg::t_state                  r_state, n_state;
    logic [ksm_pkg::VAR_W-1:0]        r_noise;
    logic [ksm_pkg::MEAS_W-1:0]       r_est;
    logic [ksm_pkg::VAR_W-1:0]        r_ev;
    logic [ksm_pkg::MEAS_W-1:0]       r_prev;
    logic [ksm_pkg::MEAS_W-1:0]       r_ad;
    logic [ksm_pkg::MEAS_W-1:0]       r_ae;
    logic                             r_eneg;
    logic [ksm_pkg::VAR_W-1:0]        r_p;
    logic [ksm_pkg::SUM_W-1:0]        r_s;
    logic [ksm_pkg::QUO_W-1:0]        r_g;
    logic [ksm_pkg::QUO_W-1:0]        r_h;
    logic [ksm_pkg::QUO_W-1:0]        r_lo;
    logic [ksm_pkg::MEAS_W-1:0]       r_out;
    logic                             r_ovalid, n_ovalid;

    logic                             accept;
    logic                             load_out;
    logic                             cfg_wr;
    logic [ksm_pkg::MEAS_W:0]         diff_d;
    logic [ksm_pkg::MEAS_W:0]         diff_e;
    logic [ksm_pkg::MUL_W-1:0]        mul_a;
    logic [ksm_pkg::MUL_W-1:0]        mul_b;
    logic [ksm_pkg::PROD_W-1:0]       prod;
    logic [64:0]                      pred_sum;
    logic [ksm_pkg::PROD_W-1:0]       acc_sum;
    logic [ksm_pkg::MEAS_W+1:0]       step;
    logic [ksm_pkg::MEAS_W+1:0]       est_next;
    ksm_pkg::t_div_req                div_req;
    ksm_pkg::t_div_rsp                div_rsp;

    assign accept   = i_valid && o_ready;
    assign o_ready  = r_state == ksm_pkg::ST_IDLE;
    assign load_out = (r_state == ksm_pkg::ST_FIN) && (!r_ovalid || i_ready);
    assign o_valid    = r_ovalid;
    assign o_estimate = r_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ksm_pkg::ADDR_W-1] == ksm_pkg::REG_NOISE_VAR);
    assign prdata = (paddr[ksm_pkg::ADDR_W-1] == ksm_pkg::REG_NOISE_VAR)
                    ? {16'b0, r_noise} : '0;

    assign diff_d = {i_measurement[31], i_measurement} - {r_prev[31], r_prev};
    assign diff_e = {i_measurement[31], i_measurement} - {r_est[31], r_est};

    always_comb begin
        case (r_state)
            ksm_pkg::ST_SQ: begin
                mul_a = {1'b0, r_ad};
                mul_b = {1'b0, r_ad};
            end
            ksm_pkg::ST_MGL: begin
                mul_a = {17'b0, r_ae[15:0]};
                mul_b = r_g;
            end
            ksm_pkg::ST_MGH: begin
                mul_a = {17'b0, r_ae[31:16]};
                mul_b = r_g;
            end
            ksm_pkg::ST_MHL: begin
                mul_a = {17'b0, r_p[15:0]};
                mul_b = r_h;
            end
            ksm_pkg::ST_MHH: begin
                mul_a = {1'b0, r_p[47:16]};
                mul_b = r_h;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ksm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        div_req.start = (r_state == ksm_pkg::ST_GS) || (r_state == ksm_pkg::ST_HS);
        div_req.num   = (r_state == ksm_pkg::ST_GS) ? r_p : r_noise;
        div_req.den   = r_s;
    end

    ksm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign pred_sum = {17'b0, r_ev} + {1'b0, prod[63:0]};
    assign acc_sum  = prod + {33'b0, r_lo};
    assign step     = r_eneg ? -{2'b00, acc_sum[47:16]} : {2'b00, acc_sum[47:16]};
    assign est_next = {{2{r_est[31]}}, r_est} + step;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ksm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = i_first_of_row ? ksm_pkg::ST_FIN : ksm_pkg::ST_SQ;
                end
            end
            ksm_pkg::ST_SQ:   n_state = ksm_pkg::ST_PRED;
            ksm_pkg::ST_PRED: n_state = ksm_pkg::ST_SUM;
            ksm_pkg::ST_SUM: begin
                if (r_p == '0 && r_noise == '0) begin
                    n_state = ksm_pkg::ST_FIN;
                end else begin
                    n_state = ksm_pkg::ST_GS;
                end
            end
            ksm_pkg::ST_GS:   n_state = ksm_pkg::ST_GW;
            ksm_pkg::ST_GW: begin
                if (div_rsp.done) begin
                    n_state = ksm_pkg::ST_HS;
                end
            end
            ksm_pkg::ST_HS:   n_state = ksm_pkg::ST_HW;
            ksm_pkg::ST_HW: begin
                if (div_rsp.done) begin
                    n_state = ksm_pkg::ST_MGL;
                end
            end
            ksm_pkg::ST_MGL:  n_state = ksm_pkg::ST_MGH;
            ksm_pkg::ST_MGH:  n_state = ksm_pkg::ST_UPX;
            ksm_pkg::ST_UPX:  n_state = ksm_pkg::ST_MHL;
            ksm_pkg::ST_MHL:  n_state = ksm_pkg::ST_MHH;
            ksm_pkg::ST_MHH:  n_state = ksm_pkg::ST_UPV;
            ksm_pkg::ST_UPV:  n_state = ksm_pkg::ST_FIN;
            ksm_pkg::ST_FIN: begin
                if (load_out) begin
                    n_state = ksm_pkg::ST_IDLE;
                end
            end
            default:          n_state = ksm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ksm_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_noise  <= ksm_pkg::NOISE_RESET;
            r_est    <= '0;
            r_ev     <= '0;
            r_prev   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                r_noise <= pwdata[ksm_pkg::VAR_W-1:0];
            end
            if (accept) begin
                r_prev <= i_measurement;
                if (i_first_of_row) begin
                    r_est <= i_measurement;
                    r_ev  <= '0;
                end
            end
            if (r_state == ksm_pkg::ST_SUM && r_p == '0 && r_noise == '0) begin
                r_ev <= '0;
            end
            if (r_state == ksm_pkg::ST_UPX) begin
                r_est <= est_next[ksm_pkg::MEAS_W-1:0];
            end
            if (r_state == ksm_pkg::ST_UPV) begin
                r_ev <= acc_sum[63:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ad   <= diff_d[ksm_pkg::MEAS_W] ? -diff_d[ksm_pkg::MEAS_W-1:0]
                                              : diff_d[ksm_pkg::MEAS_W-1:0];
            r_ae   <= diff_e[ksm_pkg::MEAS_W] ? -diff_e[ksm_pkg::MEAS_W-1:0]
                                              : diff_e[ksm_pkg::MEAS_W-1:0];
            r_eneg <= diff_e[ksm_pkg::MEAS_W];
        end
        if (r_state == ksm_pkg::ST_PRED) begin
            r_p <= (pred_sum[64:48] != '0) ? ksm_pkg::VAR_MAX : pred_sum[47:0];
        end
        if (r_state == ksm_pkg::ST_SUM) begin
            r_s <= {1'b0, r_p} + {1'b0, r_noise};
        end
        if (r_state == ksm_pkg::ST_GW && div_rsp.done) begin
            r_g <= div_rsp.quo;
        end
        if (r_state == ksm_pkg::ST_HW && div_rsp.done) begin
            r_h <= div_rsp.quo;
        end
        if (r_state == ksm_pkg::ST_MGH || r_state == ksm_pkg::ST_MHH) begin
            r_lo <= prod[48:16];
        end
        if (load_out) begin
            r_out <= r_est;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ksm_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ksm_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          o_ready,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire  signed [31:0]           o_estimate,
    input wire                          psel,
    input wire                          penable,
    input wire                          pwrite,
    input wire  [ksm_pkg::ADDR_W-1:0]   paddr,
    input wire  [ksm_pkg::DATA_W-1:0]   pwdata,
    input wire  [ksm_pkg::DATA_W-1:0]   prdata,
    input wire                          pready
);

    // A result waiting for the sink keeps its value.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_estimate))

    // Every accepted sample leaves the block busy in the following cycle.
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // Reset leaves the block idle with no pending result.
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && o_ready)

    // A written noise variance reads back on the following cycle.
    `ASSERT_CLK(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[ksm_pkg::ADDR_W-1] |=> paddr[ksm_pkg::ADDR_W-1] || prdata[ksm_pkg::VAR_W-1:0] == $past(pwdata[ksm_pkg::VAR_W-1:0]))

endmodule

bind scalar_kalman_smoother_unit ksm_checker u_ksm_checker (.*);

`default_nettype wire

FILE: sim/tb_scalar_kalman_smoother_unit.sv
`timescale 1ns / 100ps

module tb_scalar_kalman_smoother_unit;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int DRAIN_CYCLES   = 100;
    localparam int DIRECTED_ROWS  = 24;

    localparam logic [ksm_pkg::ADDR_W-1:0] NOISE_ADDR  = {ksm_pkg::REG_NOISE_VAR, 3'b000};
    localparam logic [ksm_pkg::ADDR_W-1:0] UNUSED_ADDR = {1'b1, 3'b000};

    localparam logic [31:0] EXTREMES [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                            32'hFFFF_FFFF};

    typedef struct packed {
        logic                       wr_cfg;
        logic [ksm_pkg::ADDR_W-1:0] cfg_addr;
        logic [ksm_pkg::DATA_W-1:0] cfg_data;
        logic [31:0]                meas;
        logic                       restart;
        logic                       known;
        logic [31:0]                want;
    } t_row;

    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, NOISE_ADDR, 64'd0, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h0003_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'hFFFD_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{1'b0, NOISE_ADDR, 64'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{1'b1, NOISE_ADDR, 64'd0, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h1234_0000, 1'b0, 1'b1, 32'h1234_0000},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h1234_0000, 1'b0, 1'b1, 32'h1234_0000},
        '{1'b1, UNUSED_ADDR, 64'h0000_0001_0000_0000, 32'hEDCB_0000, 1'b0, 1'b1,
          32'hEDCB_0000},
        '{1'b1, NOISE_ADDR, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h7FFF_0000, 1'b0, 1'b0, 32'h0},
        '{1'b1, NOISE_ADDR, 64'h0000_0000_8000_0000, 32'h0000_8000, 1'b1, 1'b1,
          32'h0000_8000},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h0001_8000, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{1'b1, NOISE_ADDR, 64'(ksm_pkg::NOISE_RESET), 32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
        '{1'b0, NOISE_ADDR, 64'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000}
    };

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic signed [31:0]                i_measurement;
    logic                              i_first_of_row;
    logic                              o_valid;
    logic                              i_ready;
    logic signed [31:0]                o_estimate;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ksm_pkg::ADDR_W-1:0]        paddr;
    logic [ksm_pkg::DATA_W-1:0]        pwdata;
    logic [ksm_pkg::DATA_W-1:0]        prdata;
    logic                              pready;

    logic signed [31:0]                est_q;
    logic [ksm_pkg::VAR_W-1:0]         var_q;
    logic signed [31:0]                prev_q;
    logic [ksm_pkg::VAR_W-1:0]         noise_q;

    logic [31:0]              estimates_due [$];
    logic [31:0]              want_est;
    int unsigned              mismatches = 0;
    int unsigned              cycles = 0;
    int unsigned              send_gap_pct = 0;
    int unsigned              stall_pct = 0;

    scalar_kalman_smoother_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_measurement  (i_measurement),
        .i_first_of_row (i_first_of_row),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_estimate     (o_estimate),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [32:0] ratio_q32(input logic [ksm_pkg::VAR_W-1:0] num,
                                              input logic [ksm_pkg::VAR_W:0] den);
        logic [127:0] wide;
        wide = 128'(num) << 32;
        wide = wide / 128'(den);
        return wide[32:0];
    endfunction

    function automatic logic [ksm_pkg::VAR_W-1:0] scale_q32(
        input logic [ksm_pkg::VAR_W-1:0] a,
        input logic [32:0] q);
        logic [127:0] wide;
        wide = 128'(a) * 128'(q);
        return wide[32+ksm_pkg::VAR_W-1:32];
    endfunction

    function automatic logic [31:0] filter_sample(input logic signed [31:0] m,
                                                  input logic restart);
        logic signed [32:0]         diff;
        logic signed [32:0]         innov;
        logic signed [32:0]         step;
        logic signed [32:0]         nxt;
        logic [32:0]                mag_d;
        logic [32:0]                mag_e;
        logic [32:0]                gain;
        logic [32:0]                hold;
        logic [63:0]                sq;
        logic [ksm_pkg::VAR_W-1:0]  pred;
        logic [ksm_pkg::VAR_W:0]    sum;
        if (restart) begin
            est_q = m;
            var_q = '0;
        end else begin
            diff  = m - prev_q;
            mag_d = diff[32] ? -diff : diff;
            sq    = mag_d * mag_d;
            pred  = (sq > 64'(ksm_pkg::VAR_MAX - var_q)) ? ksm_pkg::VAR_MAX
                                                         : var_q + sq[ksm_pkg::VAR_W-1:0];
            sum   = pred + noise_q;
            if (sum == '0) begin
                var_q = '0;
            end else begin
                innov = m - est_q;
                mag_e = innov[32] ? -innov : innov;
                gain  = ratio_q32(pred, sum);
                hold  = ratio_q32(noise_q, sum);
                step  = $signed(33'(scale_q32(ksm_pkg::VAR_W'(mag_e), gain)));
                if (innov[32]) begin
                    step = -step;
                end
                nxt   = est_q + step;
                est_q = nxt[31:0];
                var_q = scale_q32(pred, hold);
            end
        end
        prev_q = m;
        return est_q;
    endfunction

    task automatic write_reg(input logic [ksm_pkg::ADDR_W-1:0] addr,
                             input logic [ksm_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[ksm_pkg::ADDR_W-1] == ksm_pkg::REG_NOISE_VAR) begin
            noise_q = data[ksm_pkg::VAR_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (estimates_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [31:0] m, input logic restart,
                               input logic known, input logic [31:0] want);
        logic [31:0] predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_measurement  <= m;
        i_first_of_row <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = filter_sample(m, restart);
        estimates_due.push_back(known ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Every estimate transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (estimates_due.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected estimate transaction: got %h", o_estimate);
                end
                mismatches++;
            end else begin
                want_est = estimates_due.pop_front();
                if (o_estimate !== want_est) begin
                    if (mismatches < 10) begin
                        $display("estimate mismatch: expected %h, got %h", want_est, o_estimate);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned                sent;
        int unsigned                row_len;
        int unsigned                kind;
        int unsigned                spread;
        logic                       restart;
        logic signed [31:0]         level;
        logic signed [31:0]         meas;
        logic [ksm_pkg::DATA_W-1:0] cfg;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_measurement  <= '0;
        i_first_of_row <= 1'b0;
        i_ready        <= 1'b1;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        est_q   = '0;
        var_q   = '0;
        prev_q  = '0;
        noise_q = ksm_pkg::NOISE_RESET;
        level   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].wr_cfg) begin
                i_valid <= 1'b0;
                wait_drained();
                write_reg(DIRECTED[r].cfg_addr, DIRECTED[r].cfg_data);
            end
            send_sample(DIRECTED[r].meas, DIRECTED[r].restart, DIRECTED[r].known,
                        DIRECTED[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            i_valid <= 1'b0;
            wait_drained();
            case (phase % 6)
                0:       cfg = 64'(ksm_pkg::NOISE_RESET);
                1:       cfg = '0;
                2:       cfg = '1;
                3:       cfg = 64'($urandom_range(1, 1 << 20));
                4:       cfg = {$urandom, $urandom};
                default: cfg = {28'd0, 4'($urandom), $urandom};
            endcase
            write_reg(NOISE_ADDR, cfg);
            if (phase == 5) begin
                write_reg(UNUSED_ADDR, {$urandom, $urandom});
            end
            case (phase % 4)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    send_gap_pct = 63;
                    stall_pct    = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 63;
                end
                default: begin
                    send_gap_pct = 13;
                    stall_pct    = 13;
                end
            endcase

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                row_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 30);
                for (int k = 0; k < row_len && sent < ITEMS_PER_PHASE; k++) begin
                    if (k == 0) begin
                        restart = ($urandom_range(19) != 0);
                        if ($urandom_range(1)) begin
                            level = $urandom;
                        end
                    end else begin
                        restart = ($urandom_range(49) == 0);
                    end
                    kind = $urandom_range(15);
                    if (kind == 0) begin
                        meas = $urandom;
                    end else if (kind == 1) begin
                        meas = EXTREMES[$urandom_range(3)];
                    end else if (kind == 2) begin
                        level = $urandom;
                        meas  = level;
                    end else begin
                        spread = $urandom_range(4, 22);
                        level  = level + $urandom_range(0, 1 << spread) - (1 << (spread - 1));
                        meas   = level;
                    end
                    send_sample(meas, restart, 1'b0, 32'h0);
                    sent++;
                end
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && estimates_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
